// File: rtl/fdsf_pkg.sv
// Package for the frame damage span finder: sizes, register map, shared types.
// No dependencies; used by every module of the block except fdsf_ram.
`default_nettype none

package fdsf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int RESET_WIDTH  = 800;
    localparam int RESET_HEIGHT = 600;

    localparam int CFG_W    = 11;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int PIXEL_W  = 32;
    localparam int FIELD_W  = 10;
    localparam int TOTAL_W  = 21;
    localparam int OUT_DW   = 56;

    localparam int COL_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [0:0]
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
    } dims_t;

    typedef struct packed
    {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             full;
        logic             frame_start;
        logic             row_end;
        logic             last_row;
    } px_info_t;

endpackage

`default_nettype wire

// File: rtl/fdsf_ram.sv
// Generic single-port synchronous RAM, read-first, registered read data.
// No dependencies.
`default_nettype none

module fdsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem_reg[addr];
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/fdsf_cfg.sv
// APB register file for frame width and height, with clamping to the maxima.
// Depends on fdsf_pkg.
`default_nettype none

module fdsf_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fdsf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fdsf_pkg::APB_DW-1:0]   pwdata,
    output logic      [fdsf_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output fdsf_pkg::dims_t                    dims,
    output logic                               restart
);

    logic [fdsf_pkg::CFG_W-1:0] width_reg;
    logic [fdsf_pkg::CFG_W-1:0] height_reg;
    fdsf_pkg::reg_index_t       index;

    assign index   = fdsf_pkg::reg_index_t'(paddr[2]);
    assign restart = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fdsf_pkg::CFG_W'(fdsf_pkg::RESET_WIDTH);
            height_reg <= fdsf_pkg::CFG_W'(fdsf_pkg::RESET_HEIGHT);
        end
        else if (restart)
        begin
            unique case (index)
                fdsf_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[fdsf_pkg::CFG_W-1:0];
                fdsf_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[fdsf_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            fdsf_pkg::REG_FRAME_WIDTH:
                prdata = fdsf_pkg::APB_DW'(width_reg);
            fdsf_pkg::REG_FRAME_HEIGHT:
                prdata = fdsf_pkg::APB_DW'(height_reg);
            default:
                prdata = '0;
        endcase
    end

    // zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (width_reg == '0)
            dims.width = fdsf_pkg::COL_W'(1);
        else if (32'(width_reg) > 32'(fdsf_pkg::MAX_WIDTH))
            dims.width = fdsf_pkg::COL_W'(fdsf_pkg::MAX_WIDTH);
        else
            dims.width = fdsf_pkg::COL_W'(width_reg);

        if (height_reg == '0)
            dims.height = fdsf_pkg::ROW_W'(1);
        else if (32'(height_reg) > 32'(fdsf_pkg::MAX_HEIGHT))
            dims.height = fdsf_pkg::ROW_W'(fdsf_pkg::MAX_HEIGHT);
        else
            dims.height = fdsf_pkg::ROW_W'(height_reg);
    end

endmodule

`default_nettype wire

// File: rtl/fdsf_raster.sv
// Raster position tracking, shadow-valid and full-frame flags, shadow address.
// Depends on fdsf_pkg.
`default_nettype none

module fdsf_raster (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          restart,
    input  wire fdsf_pkg::dims_t               dims,
    input  wire logic                          pixel_accept,
    input  wire logic                          inval_accept,
    output fdsf_pkg::px_info_t                 info,
    output logic      [fdsf_pkg::ADDR_W-1:0]   addr
);

    logic [fdsf_pkg::COL_W-1:0] col_reg, col_next;
    logic [fdsf_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       valid_reg, valid_next;
    logic                       full_reg, full_next;
    logic [fdsf_pkg::COL_W-1:0] col_inc;
    logic [fdsf_pkg::ROW_W-1:0] row_inc;

    assign col_inc = col_reg + fdsf_pkg::COL_W'(1);
    assign row_inc = row_reg + fdsf_pkg::ROW_W'(1);

    always_comb
    begin
        info.col         = col_reg;
        info.row         = row_reg;
        info.frame_start = (col_reg == '0) && (row_reg == '0);
        info.full        = info.frame_start ? !valid_reg : full_reg;
        info.row_end     = (col_inc == dims.width);
        info.last_row    = (row_inc >= dims.height);
    end

    assign addr = fdsf_pkg::ADDR_W'(row_reg) * fdsf_pkg::ADDR_W'(fdsf_pkg::MAX_WIDTH)
                + fdsf_pkg::ADDR_W'(col_reg);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        full_next  = full_reg;
        if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            valid_next = 1'b0;
            full_next  = 1'b0;
        end
        else if (inval_accept)
        begin
            valid_next = 1'b0;
        end
        else if (pixel_accept)
        begin
            full_next = info.full;
            if (info.frame_start)
                valid_next = 1'b1;
            if (info.row_end)
            begin
                col_next = '0;
                if (info.last_row)
                begin
                    row_next  = '0;
                    full_next = 1'b0;
                end
                else
                begin
                    row_next = row_inc;
                end
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
            full_reg  <= full_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fdsf_span.sv
// Compare stage: shadow diff, per-row span tracking, pixel total, output word.
// Depends on fdsf_pkg.
`default_nettype none

module fdsf_span (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           restart,
    input  wire logic                           load,
    input  wire fdsf_pkg::px_info_t             info,
    input  wire logic [fdsf_pkg::PIXEL_W-1:0]   pixel,
    input  wire logic [fdsf_pkg::PIXEL_W-1:0]   shadow,
    output logic                                ready,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [fdsf_pkg::OUT_DW-1:0]    m_tdata,   // row, start, end, pixels
    output logic                                m_tuser,   // span_present
    output logic                                m_tlast    // frame_done
);

    localparam int SUM_W = fdsf_pkg::TOTAL_W + 1;

    fdsf_pkg::px_info_t           info_reg;
    logic [fdsf_pkg::PIXEL_W-1:0] pixel_reg;
    logic                         s1_valid_reg;
    logic [fdsf_pkg::COL_W-1:0]   first_reg, last_reg;
    logic                         dirty_reg;
    logic [fdsf_pkg::TOTAL_W-1:0] total_reg;

    logic                         out_valid_reg;
    logic [fdsf_pkg::FIELD_W-1:0] row_out_reg, start_out_reg, end_out_reg;
    logic                         present_out_reg, done_out_reg;
    logic [fdsf_pkg::TOTAL_W-1:0] pixels_out_reg;

    logic                         differs, dirty_now, has_res, fire;
    logic [fdsf_pkg::COL_W-1:0]   first_now, last_now, span;
    logic [fdsf_pkg::TOTAL_W-1:0] base, total_now;
    logic [SUM_W-1:0]             sum;

    always_comb
    begin
        differs   = info_reg.full || (shadow != pixel_reg);
        dirty_now = dirty_reg || differs;
        first_now = dirty_reg ? first_reg : info_reg.col;
        last_now  = differs ? info_reg.col : last_reg;
        span      = last_now - first_now + fdsf_pkg::COL_W'(1);
        base      = info_reg.frame_start ? '0 : total_reg;
        sum       = SUM_W'(base) + SUM_W'(span);
        if (info_reg.row_end && dirty_now)
            total_now = (sum > SUM_W'(fdsf_pkg::TOTAL_MAX)) ? fdsf_pkg::TOTAL_MAX
                                                            : sum[fdsf_pkg::TOTAL_W-1:0];
        else
            total_now = base;
        has_res = info_reg.row_end && (dirty_now || info_reg.last_row);
        ready   = !(s1_valid_reg && has_res && out_valid_reg && !m_tready);
        fire    = s1_valid_reg && ready;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            info_reg  <= info;
            pixel_reg <= pixel;
        end
        if (fire && has_res)
        begin
            row_out_reg     <= info_reg.row[fdsf_pkg::FIELD_W-1:0];
            start_out_reg   <= dirty_now ? first_now[fdsf_pkg::FIELD_W-1:0] : '0;
            end_out_reg     <= dirty_now ? last_now[fdsf_pkg::FIELD_W-1:0] : '0;
            present_out_reg <= dirty_now;
            done_out_reg    <= info_reg.last_row;
            pixels_out_reg  <= info_reg.last_row ? total_now : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            dirty_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                s1_valid_reg <= 1'b0;
                first_reg    <= '0;
                last_reg     <= '0;
                dirty_reg    <= 1'b0;
                total_reg    <= '0;
            end
            else
            begin
                if (load)
                    s1_valid_reg <= 1'b1;
                else if (fire)
                    s1_valid_reg <= 1'b0;
                if (fire)
                begin
                    total_reg <= total_now;
                    if (info_reg.row_end)
                    begin
                        first_reg <= '0;
                        last_reg  <= '0;
                        dirty_reg <= 1'b0;
                    end
                    else
                    begin
                        first_reg <= first_now;
                        last_reg  <= last_now;
                        dirty_reg <= dirty_now;
                    end
                end
            end
            if (fire && has_res)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, pixels_out_reg, end_out_reg, start_out_reg, row_out_reg};
    assign m_tuser  = present_out_reg;
    assign m_tlast  = done_out_reg;

endmodule

`default_nettype wire

// File: rtl/frame_damage_span_finder_core.sv
// Top level of the frame damage span finder: raster tracker, shadow RAM, compare stage.
// Depends on fdsf_pkg, fdsf_cfg, fdsf_raster, fdsf_ram, fdsf_span.
//
//  channel  | direction | words / fields
//  ---------+-----------+---------------------------------------------------------
//  s_*      | in        | tdata[31:0] pixel, tuser mode (1 = invalidate)
//  m_*      | out       | tdata row[9:0] start[19:10] end[29:20] pixels[50:30],
//           |           | tuser span_present, tlast frame_done
//  APB      | in/out    | 0x0 frame_width, 0x4 frame_height (11 bits each)
//
// One word per cycle while s_tready is high; a pixel word reads and writes the shadow RAM
// at the same address in its accept cycle (read-first); the compare runs in the next cycle
// on the registered data, and a row's span then passes through the output registers to m_*.
// The shadow RAM needs no clearing after reset: the first frame is always pushed whole.
// s_tready drops only while a result is held in the compare stage behind an unread output.
`default_nettype none

module frame_damage_span_finder_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [fdsf_pkg::PIXEL_W-1:0]         s_tdata,   // pixel
    input  wire logic                                 s_tuser,   // mode
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [fdsf_pkg::OUT_DW-1:0]          m_tdata,   // row, start, end, pixels
    output logic                                      m_tuser,   // span_present
    output logic                                      m_tlast,   // frame_done
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [fdsf_pkg::APB_AW-1:0]          paddr,
    input  wire logic [fdsf_pkg::APB_DW-1:0]          pwdata,
    output logic      [fdsf_pkg::APB_DW-1:0]          prdata,
    output logic                                      pready
);

    fdsf_pkg::dims_t               dims;
    fdsf_pkg::px_info_t            info;
    logic                          restart;
    logic                          accept, pixel_accept, inval_accept;
    logic [fdsf_pkg::ADDR_W-1:0]   addr;
    logic [fdsf_pkg::PIXEL_W-1:0]  shadow;

    assign accept       = s_tvalid && s_tready;
    assign pixel_accept = accept && !s_tuser;
    assign inval_accept = accept && s_tuser;

    fdsf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims),
        .restart (restart)
    );

    fdsf_raster u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .dims         (dims),
        .pixel_accept (pixel_accept),
        .inval_accept (inval_accept),
        .info         (info),
        .addr         (addr)
    );

    fdsf_ram #(
        .WIDTH (fdsf_pkg::PIXEL_W),
        .DEPTH (fdsf_pkg::DEPTH)
    ) u_shadow (
        .clk   (clk),
        .en    (pixel_accept),
        .we    (pixel_accept),
        .addr  (addr),
        .wdata (s_tdata),
        .rdata (shadow)
    );

    fdsf_span u_span (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .load     (pixel_accept),
        .info     (info),
        .pixel    (s_tdata),
        .shadow   (shadow),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
